// ----- design/nrr_pkg.sv -----
`default_nettype none

package nrr_pkg;

  // held store
  localparam int HOLD_DEPTH = 32;
  localparam int ADDR_W     = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int ZCNT_W     = $clog2(HOLD_DEPTH + 2);

  // sample format
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int SUM_W  = 38;
  localparam int UNIT_W = SUM_W - FRAC_W;
  localparam int DIVD_W = UNIT_W - 1;
  localparam int DCNT_W = $clog2(DIVD_W + 1);

  // window setting
  localparam int WIN_W = 6;
  localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam logic [WIN_W-1:0] MIN_WINDOW_LOW = WIN_W'(2);

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_WINDOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW   = 2'd2;

  // config register indexes
  localparam logic REG_UPPER_LIMIT = 1'b0;
  localparam logic REG_MIN_WINDOW  = 1'b1;

endpackage

`default_nettype wire

// ----- design/nrr_hold_ram.sv -----
`default_nettype none

module nrr_hold_ram
  import nrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [VAL_W-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [VAL_W-1:0]  rdata
);

  logic [VAL_W-1:0] mem [HOLD_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/nrr_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module nrr_div
  import nrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic      [DIVD_W-1:0] quotient
);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [DCNT_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, quotient[DIVD_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= DCNT_W'(DIVD_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= CNT_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[CNT_W-1:0];
        end
        quotient <= {quotient[DIVD_W-2:0], fits};
        steps    <= steps - 1'b1;
        if (steps == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/noisy_run_repair.sv -----
`default_nettype none

// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    sample, series_end
// out       out  out_valid/out_ready  value, status, run_last
// cfg       in   cfg_we               cfg_index, cfg_data (write only)
//
// Sequencing: a pass-through or held request is taken in S_IDLE. A run close
// runs the fill divide (S_DIV) when the run saw a negative sample, then
// reads each held entry (S_RD) and loads it out (S_EMIT), then the closing
// sample (S_TAIL). A zero flush gives one result per cycle unless stalled.
// Reset is synchronous; held entries past the fill count are never read, so
// the store needs no clearing pass. Output stalls hold the sequencer.

module noisy_run_repair
  import nrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input requests
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [VAL_W-1:0] sample,
  input  wire logic              series_end,
  // results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [VAL_W-1:0] value,
  output logic [1:0]             status,
  output logic                   run_last,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [VAL_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_EMIT,
    S_TAIL,
    S_ZERO
  } state_t;

  state_t state;

  // config
  logic signed [VAL_W-1:0] upper_limit;
  logic [WIN_W-1:0]        min_window;

  // run state
  logic [CNT_W-1:0]         held_count;
  logic                     in_run;
  logic                     clean_started;
  logic [CNT_W-1:0]         clean_pos;
  logic                     saw_neg;
  logic signed [UNIT_W-1:0] run_units;   // running sum in whole units
  logic signed [UNIT_W-1:0] noisy_units; // sum of the noisy part

  // sequencer
  logic [CNT_W-1:0]        idx;
  logic [ZCNT_W-1:0]       zero_left;
  logic [1:0]              zero_status;
  logic signed [VAL_W-1:0] cur_sample;
  logic [VAL_W-1:0]        fill;

  // decode of the incoming request
  logic                     take;
  logic                     out_free;
  logic                     good;
  logic                     win_bad;
  logic                     open_run;
  logic                     close_run;
  logic                     overflow;
  logic                     hold;
  logic                     need_div;
  logic signed [SUM_W-1:0]  sum_t;
  logic signed [UNIT_W-1:0] units_next;
  logic [CNT_W-1:0]         held_next;
  logic [CNT_W-1:0]         streak_len;
  logic [CNT_W-1:0]         idx_next;

  // RAM and divider hookup
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [VAL_W-1:0]  ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVD_W-1:0] div_quot;

  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == S_IDLE) && out_free;
    take       = in_valid && in_ready;
    good       = (sample > 0) && (sample < upper_limit);
    streak_len = held_count - clean_pos;

    win_bad   = min_window < MIN_WINDOW_LOW;
    open_run  = !win_bad && !in_run && !good;
    close_run = !win_bad && in_run && good && clean_started &&
                (CMP_W'(streak_len) == CMP_W'(min_window));
    overflow  = !win_bad && in_run && !close_run &&
                (held_count >= CNT_W'(HOLD_DEPTH));
    hold      = !win_bad && in_run && !close_run && !overflow;
    need_div  = saw_neg && (clean_pos != '0);

    // add with truncation toward zero to a whole unit
    sum_t = $signed({(open_run ? UNIT_W'(0) : run_units), FRAC_W'(0)}) + SUM_W'(sample);
    units_next = sum_t[SUM_W-1:FRAC_W] +
                 UNIT_W'(sum_t[SUM_W-1] && (sum_t[FRAC_W-1:0] != '0));
    held_next  = open_run ? CNT_W'(1) : held_count + 1'b1;

    idx_next  = idx + 1'b1;
    ram_we    = take && (open_run || hold);
    ram_waddr = open_run ? '0 : held_count[ADDR_W-1:0];
    ram_re    = (state == S_RD);
    div_start = take && close_run && need_div;
    // negative noisy sum floors the fill at zero
    div_dividend = noisy_units[UNIT_W-1] ? '0 : noisy_units[DIVD_W-1:0];
  end

  nrr_hold_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (sample),
    .re    (ram_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  nrr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (clean_pos),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      upper_limit   <= {1'b0, {(VAL_W-1){1'b1}}};
      min_window    <= MIN_WINDOW_LOW;
      held_count    <= '0;
      in_run        <= 1'b0;
      clean_started <= 1'b0;
      clean_pos     <= '0;
      saw_neg       <= 1'b0;
      run_units     <= '0;
      noisy_units   <= '0;
      idx           <= '0;
      zero_left     <= '0;
      zero_status   <= ST_OK;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_UPPER_LIMIT: upper_limit <= cfg_data;
          REG_MIN_WINDOW:  min_window  <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            if (win_bad) begin
              // pass through flagged; end of series drops an open run
              out_valid <= 1'b1;
              value     <= sample;
              status    <= ST_BAD_WINDOW;
              run_last  <= 1'b1;
              if (series_end) begin
                in_run        <= 1'b0;
                clean_started <= 1'b0;
                clean_pos     <= '0;
                saw_neg       <= 1'b0;
                held_count    <= '0;
                run_units     <= '0;
                noisy_units   <= '0;
              end
            end else if (!in_run && good) begin
              out_valid <= 1'b1;
              value     <= sample;
              status    <= ST_OK;
              run_last  <= 1'b1;
            end else if (close_run) begin
              cur_sample <= sample;
              idx        <= '0;
              state      <= need_div ? S_DIV : S_RD;
            end else if (overflow) begin
              zero_left     <= ZCNT_W'(held_count) + 1'b1;
              zero_status   <= ST_OVERFLOW;
              state         <= S_ZERO;
              in_run        <= 1'b0;
              clean_started <= 1'b0;
              clean_pos     <= '0;
              saw_neg       <= 1'b0;
              held_count    <= '0;
              run_units     <= '0;
              noisy_units   <= '0;
            end else if (series_end) begin
              // sample is held, then the open run goes out as zeros
              zero_left     <= ZCNT_W'(held_next);
              zero_status   <= ST_OK;
              state         <= S_ZERO;
              in_run        <= 1'b0;
              clean_started <= 1'b0;
              clean_pos     <= '0;
              saw_neg       <= 1'b0;
              held_count    <= '0;
              run_units     <= '0;
              noisy_units   <= '0;
            end else begin
              held_count <= held_next;
              run_units  <= units_next;
              in_run     <= 1'b1;
              if (open_run) begin
                clean_started <= 1'b0;
                clean_pos     <= '0;
                noisy_units   <= '0;
                saw_neg       <= sample[VAL_W-1];
              end else if (good) begin
                if (!clean_started) begin
                  clean_started <= 1'b1;
                  clean_pos     <= held_count;
                  noisy_units   <= run_units;
                end
              end else begin
                clean_started <= 1'b0;
                if (sample[VAL_W-1]) begin
                  saw_neg <= 1'b1;
                end
              end
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            fill  <= {div_quot[VAL_W-FRAC_W-1:0], FRAC_W'(0)};
            state <= S_RD;
          end
        end

        S_RD: begin
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= (saw_neg && (idx < clean_pos)) ? fill : ram_rdata;
            status    <= ST_OK;
            run_last  <= 1'b0;
            idx       <= idx_next;
            state     <= (idx_next == held_count) ? S_TAIL : S_RD;
          end
        end

        S_TAIL: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            value         <= cur_sample;
            status        <= ST_OK;
            run_last      <= 1'b1;
            state         <= S_IDLE;
            in_run        <= 1'b0;
            clean_started <= 1'b0;
            clean_pos     <= '0;
            saw_neg       <= 1'b0;
            held_count    <= '0;
            run_units     <= '0;
            noisy_units   <= '0;
          end
        end

        S_ZERO: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= '0;
            status    <= zero_status;
            run_last  <= (zero_left == ZCNT_W'(1));
            zero_left <= zero_left - 1'b1;
            if (zero_left == ZCNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
